### design/sensor_block_statistics_unit_assert.svh
// assertion macros for the sensor block statistics unit
// expects clk and arst_n in the scope of the module that uses them
`ifndef SENSOR_BLOCK_STATISTICS_UNIT_ASSERT_SVH
`define SENSOR_BLOCK_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication
`define SBS_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");

// next-cycle implication
`define SBS_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");

`endif

### design/sbs_pkg.sv
// shared types and constants for the sensor block statistics unit
// no dependencies
`timescale 1ns / 1ps

package sbs_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int IN_W       = SAMPLE_W + 1;
	localparam int CNT_W      = 15;
	localparam int SUM_W      = 24;
	localparam int SQ_W       = 35;
	localparam int MEAN_W     = 18;
	localparam int DEV_W      = 18;
	localparam int MEAN_SHIFT = 8;
	localparam int VAR_SHIFT  = 16;
	localparam int DVD_W      = SQ_W + VAR_SHIFT;
	localparam int REM_W      = 14;
	localparam int ALU_W      = 21;
	localparam int RAD_W      = 2 * DEV_W;
	localparam int STEP_W     = 6;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 104;
	localparam int APB_W      = 32;
	localparam int ADDR_W     = 2;

	localparam logic [CNT_W-1:0]    MAX_BLOCK     = 15'd16384;
	localparam logic [CNT_W-1:0]    BLK_LEN_RESET = 15'd100;
	localparam logic [SAMPLE_W-1:0] EMPTY_LOW     = 10'd100;
	localparam logic [IN_W-1:0]     MARK_MISSING  = 11'h7FF;
	localparam logic [STEP_W-1:0]   DIV_LAST      = 6'd50;
	localparam logic [STEP_W-1:0]   ROOT_LAST     = 6'd17;
	localparam logic [ADDR_W-1:0]   ADDR_BLK_LEN  = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_MEAN,
		ST_DIV_VAR,
		ST_SQUARE,
		ST_DIFF,
		ST_ROOT,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [CNT_W-1:0]    good;
		logic [CNT_W-1:0]    lost;
		logic [CNT_W-1:0]    bad;
		logic [SAMPLE_W-1:0] top;
		logic [SAMPLE_W-1:0] bottom;
		logic [SUM_W-1:0]    sum;
		logic [SQ_W-1:0]     sq;
	} blk_totals_t;

	typedef struct packed {
		logic [CNT_W-1:0]    valid_total;
		logic [CNT_W-1:0]    missing_total;
		logic [CNT_W-1:0]    corrupted_total;
		logic [SAMPLE_W-1:0] peak_high;
		logic [SAMPLE_W-1:0] peak_low;
		logic [MEAN_W-1:0]   average_q8;
		logic [DEV_W-1:0]    deviation_q8;
	} blk_result_t;

endpackage

### design/sbs_alu.sv
// shared compare and subtract unit used by the divider and square root steps
// depends on sbs_pkg
`timescale 1ns / 1ps

module sbs_alu (
	input  logic [sbs_pkg::ALU_W-1:0] a,
	input  logic [sbs_pkg::ALU_W-1:0] b,
	output logic [sbs_pkg::ALU_W-1:0] diff,
	output logic                      ge
);

	logic [sbs_pkg::ALU_W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[sbs_pkg::ALU_W-1:0];
	assign ge   = ~full[sbs_pkg::ALU_W];

endmodule

### design/sbs_accum.sv
// per-sample accumulators: counts, sum, sum of squares, max and min
// depends on sbs_pkg
`timescale 1ns / 1ps

module sbs_accum (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [sbs_pkg::IN_W-1:0]     sample,
	input  logic [sbs_pkg::CNT_W-1:0]    blk_len,
	output logic                         close,
	output sbs_pkg::blk_totals_t         totals
);

	logic [sbs_pkg::CNT_W-1:0]      seen_q, good_q, lost_q, bad_q;
	logic [sbs_pkg::CNT_W-1:0]      seen_d, good_d, lost_d, bad_d;
	logic [sbs_pkg::SAMPLE_W-1:0]   top_q, bottom_q, top_d, bottom_d;
	logic [sbs_pkg::SUM_W-1:0]      sum_q, sum_d;
	logic [sbs_pkg::SQ_W-1:0]       sq_q, sq_d;
	logic [sbs_pkg::CNT_W-1:0]      size;
	logic [sbs_pkg::SAMPLE_W-1:0]   value;
	logic [2*sbs_pkg::SAMPLE_W-1:0] square;
	logic                           is_neg;

	assign value  = sample[sbs_pkg::SAMPLE_W-1:0];
	assign is_neg = sample[sbs_pkg::IN_W-1];
	assign square = value * value;

	always_comb begin
		size = blk_len;
		if (blk_len == '0) begin
			size = sbs_pkg::CNT_W'(1);
		end else if (blk_len > sbs_pkg::MAX_BLOCK) begin
			size = sbs_pkg::MAX_BLOCK;
		end
		seen_d   = seen_q + sbs_pkg::CNT_W'(1);
		good_d   = good_q;
		lost_d   = lost_q;
		bad_d    = bad_q;
		top_d    = top_q;
		bottom_d = bottom_q;
		sum_d    = sum_q;
		sq_d     = sq_q;
		if (is_neg) begin
			if (sample == sbs_pkg::MARK_MISSING) begin
				lost_d = lost_q + sbs_pkg::CNT_W'(1);
			end else begin
				bad_d = bad_q + sbs_pkg::CNT_W'(1);
			end
		end else begin
			if (good_q == '0) begin
				top_d    = value;
				bottom_d = value;
			end else begin
				if (value > top_q) top_d = value;
				if (value < bottom_q) bottom_d = value;
			end
			good_d = good_q + sbs_pkg::CNT_W'(1);
			sum_d  = sum_q + sbs_pkg::SUM_W'(value);
			sq_d   = sq_q + sbs_pkg::SQ_W'(square);
		end
		close = (seen_d >= size);
	end

	assign totals.good   = good_d;
	assign totals.lost   = lost_d;
	assign totals.bad    = bad_d;
	assign totals.top    = top_d;
	assign totals.bottom = bottom_d;
	assign totals.sum    = sum_d;
	assign totals.sq     = sq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			good_q   <= '0;
			lost_q   <= '0;
			bad_q    <= '0;
			top_q    <= '0;
			bottom_q <= sbs_pkg::EMPTY_LOW;
			sum_q    <= '0;
			sq_q     <= '0;
		end else if (take) begin
			if (close) begin
				seen_q   <= '0;
				good_q   <= '0;
				lost_q   <= '0;
				bad_q    <= '0;
				top_q    <= '0;
				bottom_q <= sbs_pkg::EMPTY_LOW;
				sum_q    <= '0;
				sq_q     <= '0;
			end else begin
				seen_q   <= seen_d;
				good_q   <= good_d;
				lost_q   <= lost_d;
				bad_q    <= bad_d;
				top_q    <= top_d;
				bottom_q <= bottom_d;
				sum_q    <= sum_d;
				sq_q     <= sq_d;
			end
		end
	end

endmodule

### design/sbs_seq.sv
// block-end sequencer: two long divisions, mean square, clamp and integer square root
// depends on sbs_pkg and sbs_alu
`timescale 1ns / 1ps

module sbs_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  sbs_pkg::blk_totals_t  totals,
	input  logic                  out_free,
	output logic                  idle,
	output logic                  res_valid,
	output sbs_pkg::blk_result_t  res
);

	sbs_pkg::seq_state_t state_q, state_d;

	logic [sbs_pkg::STEP_W-1:0]   cnt_q;
	sbs_pkg::blk_totals_t         snap_q;
	logic [sbs_pkg::DVD_W-1:0]    dvd_q, quo_q, quo_d, var_gap;
	logic [sbs_pkg::REM_W-1:0]    rem_q, rem_d;
	logic [sbs_pkg::MEAN_W-1:0]   mean_q;
	logic [2*sbs_pkg::MEAN_W-1:0] msq_q;
	logic [sbs_pkg::RAD_W-1:0]    rad_q;
	logic [sbs_pkg::ALU_W-3:0]    rrem_q, rrem_d;
	logic [sbs_pkg::DEV_W-1:0]    root_q, root_d;
	logic [sbs_pkg::ALU_W-1:0]    alu_a, alu_b, alu_diff;
	logic                         alu_ge;

	sbs_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	always_comb begin
		if (state_q == sbs_pkg::ST_ROOT) begin
			alu_a = {rrem_q, rad_q[sbs_pkg::RAD_W-1 -: 2]};
			alu_b = {1'b0, root_q, 2'b01};
		end else begin
			alu_a = sbs_pkg::ALU_W'({rem_q, dvd_q[sbs_pkg::DVD_W-1]});
			alu_b = sbs_pkg::ALU_W'(snap_q.good);
		end
	end

	assign quo_d   = {quo_q[sbs_pkg::DVD_W-2:0], alu_ge};
	assign rem_d   = alu_ge ? alu_diff[sbs_pkg::REM_W-1:0]
	                        : {rem_q[sbs_pkg::REM_W-2:0], dvd_q[sbs_pkg::DVD_W-1]};
	assign rrem_d  = alu_ge ? alu_diff[sbs_pkg::ALU_W-3:0] : alu_a[sbs_pkg::ALU_W-3:0];
	assign root_d  = {root_q[sbs_pkg::DEV_W-2:0], alu_ge};
	assign var_gap = quo_q - sbs_pkg::DVD_W'(msq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + sbs_pkg::STEP_W'(1);
		end
	end

	always_comb begin
		state_d   = state_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			sbs_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					state_d = (totals.good != '0) ? sbs_pkg::ST_DIV_MEAN : sbs_pkg::ST_DONE;
				end
			end
			sbs_pkg::ST_DIV_MEAN: begin
				if (cnt_q == sbs_pkg::DIV_LAST) state_d = sbs_pkg::ST_DIV_VAR;
			end
			sbs_pkg::ST_DIV_VAR: begin
				if (cnt_q == sbs_pkg::DIV_LAST) state_d = sbs_pkg::ST_SQUARE;
			end
			sbs_pkg::ST_SQUARE: begin
				state_d = sbs_pkg::ST_DIFF;
			end
			sbs_pkg::ST_DIFF: begin
				state_d = sbs_pkg::ST_ROOT;
			end
			sbs_pkg::ST_ROOT: begin
				if (cnt_q == sbs_pkg::ROOT_LAST) state_d = sbs_pkg::ST_DONE;
			end
			sbs_pkg::ST_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = sbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sbs_pkg::ST_IDLE: begin
				if (start) begin
					snap_q <= totals;
					dvd_q  <= sbs_pkg::DVD_W'({totals.sum, sbs_pkg::MEAN_SHIFT'(0)});
					rem_q  <= '0;
					mean_q <= '0;
					root_q <= '0;
				end
			end
			sbs_pkg::ST_DIV_MEAN: begin
				quo_q <= quo_d;
				if (cnt_q == sbs_pkg::DIV_LAST) begin
					mean_q <= quo_d[sbs_pkg::MEAN_W-1:0];
					dvd_q  <= {snap_q.sq, sbs_pkg::VAR_SHIFT'(0)};
					rem_q  <= '0;
				end else begin
					dvd_q <= {dvd_q[sbs_pkg::DVD_W-2:0], 1'b0};
					rem_q <= rem_d;
				end
			end
			sbs_pkg::ST_DIV_VAR: begin
				quo_q <= quo_d;
				dvd_q <= {dvd_q[sbs_pkg::DVD_W-2:0], 1'b0};
				rem_q <= rem_d;
			end
			sbs_pkg::ST_SQUARE: begin
				msq_q <= mean_q * mean_q;
			end
			sbs_pkg::ST_DIFF: begin
				rad_q  <= (quo_q > sbs_pkg::DVD_W'(msq_q)) ? var_gap[sbs_pkg::RAD_W-1:0] : '0;
				rrem_q <= '0;
				root_q <= '0;
			end
			sbs_pkg::ST_ROOT: begin
				rad_q  <= {rad_q[sbs_pkg::RAD_W-3:0], 2'b00};
				rrem_q <= rrem_d;
				root_q <= root_d;
			end
			default: begin
			end
		endcase
	end

	assign res.valid_total     = snap_q.good;
	assign res.missing_total   = snap_q.lost;
	assign res.corrupted_total = snap_q.bad;
	assign res.peak_high       = snap_q.top;
	assign res.peak_low        = snap_q.bottom;
	assign res.average_q8      = mean_q;
	assign res.deviation_q8    = root_q;

endmodule

### design/sensor_block_statistics_unit.sv
// Sensor block statistics: takes one 11-bit sample word per accepted beat (a 0..1023
// reading, -1 for missing, -2 or any other negative for corrupted) and after a block of
// samples, as long as the block length register says, emits one result word with the
// valid, missing and corrupted counts, max, min, mean and population standard deviation
// in unsigned Q.8. A sample that does not close a block is taken and the input stays
// ready. The sample that closes a block holds the input off through two 51-step
// shift-subtract divisions, a squaring step, a subtract step and an 18-step square
// root (divisions and root share one compare/subtract unit), and longer if the previous
// result has not yet been taken; a block with no valid samples skips the arithmetic.
// Results wait in an output register, so samples keep flowing while a result is
// pending. The block length register is at byte address 0 of the register port; 0 acts
// as 1 and values above 16384 act as 16384.
// depends on sbs_pkg, sbs_accum, sbs_seq and the assertion macro header
`timescale 1ns / 1ps
`include "sensor_block_statistics_unit_assert.svh"

module sensor_block_statistics_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // sample[10:0], zero pad
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// valid_total, missing_total, corrupted_total, peak_high, peak_low, average_q8,
	// deviation_q8, zero pad
	output logic [sbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbs_pkg::ADDR_W-1:0]       paddr,
	input  logic [sbs_pkg::APB_W-1:0]        pwdata,
	output logic [sbs_pkg::APB_W-1:0]        prdata,
	output logic                             pready
);

	logic [sbs_pkg::CNT_W-1:0]      blk_len_q;
	logic                           out_valid_q;
	logic [sbs_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           take, close, idle, res_valid, out_free;
	sbs_pkg::blk_totals_t           totals;
	sbs_pkg::blk_result_t           res;

	assign pready = 1'b1;
	assign prdata = sbs_pkg::APB_W'(blk_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= sbs_pkg::BLK_LEN_RESET;
		end else if (psel && penable && pwrite && pready && paddr == sbs_pkg::ADDR_BLK_LEN) begin
			blk_len_q <= pwdata[sbs_pkg::CNT_W-1:0];
		end
	end

	assign s_axis_tready = idle;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	sbs_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.sample  (s_axis_tdata[sbs_pkg::IN_W-1:0]),
		.blk_len (blk_len_q),
		.close   (close),
		.totals  (totals)
	);

	sbs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (take && close),
		.totals    (totals),
		.out_free  (out_free),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= {3'b000, res.deviation_q8, res.average_q8, res.peak_low,
				res.peak_high, res.corrupted_total, res.missing_total, res.valid_total};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`SBS_ASSERT_IMP(a_no_overwrite, res_valid, !out_valid_q || m_axis_tready)
	`SBS_ASSERT_NXT(a_busy_after_close, take && close, !s_axis_tready)
	`SBS_ASSERT_IMP(a_empty_block, res_valid && res.valid_total == '0,
		res.average_q8 == '0 && res.deviation_q8 == '0 && res.peak_low == sbs_pkg::EMPTY_LOW)

endmodule

### tb/tb_top.sv
// testbench for sensor_block_statistics_unit: random and directed sample streams with
// block size changes over the register port, checked result by result against a predictor
// depends on sbs_pkg and the sensor_block_statistics_unit rtl
`timescale 1ns / 1ps

module tb_top;

	localparam int IN_W       = sbs_pkg::IN_W;
	localparam int CNT_W      = sbs_pkg::CNT_W;
	localparam int SAMPLE_W   = sbs_pkg::SAMPLE_W;
	localparam int SUM_W      = sbs_pkg::SUM_W;
	localparam int SQ_W       = sbs_pkg::SQ_W;
	localparam int MEAN_W     = sbs_pkg::MEAN_W;
	localparam int DEV_W      = sbs_pkg::DEV_W;
	localparam int MEAN_SHIFT = sbs_pkg::MEAN_SHIFT;
	localparam int VAR_SHIFT  = sbs_pkg::VAR_SHIFT;
	localparam int IN_DATA_W  = sbs_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = sbs_pkg::OUT_DATA_W;
	localparam int APB_W      = sbs_pkg::APB_W;
	localparam int ADDR_W     = sbs_pkg::ADDR_W;

	localparam logic [CNT_W-1:0]    MAX_BLOCK     = sbs_pkg::MAX_BLOCK;
	localparam logic [CNT_W-1:0]    BLK_LEN_RESET = sbs_pkg::BLK_LEN_RESET;
	localparam logic [SAMPLE_W-1:0] EMPTY_LOW     = sbs_pkg::EMPTY_LOW;
	localparam logic [IN_W-1:0]     MARK_MISSING  = sbs_pkg::MARK_MISSING;
	localparam logic [ADDR_W-1:0]   ADDR_BLK_LEN  = sbs_pkg::ADDR_BLK_LEN;

	localparam int WATCH_LIMIT = 20000;
	localparam int SETTLE      = 200;
	localparam int TAIL        = 300;
	localparam int HOLD_CYCLES = 3000;
	localparam int RAND_PHASES = 12;
	localparam int LONG_RUN    = 400;
	localparam int MAX_PRINT   = 100;

	localparam logic [IN_W-1:0] MARK_CORRUPT = 11'h7FE;
	localparam logic [IN_W-1:0] MOST_NEG     = 11'h400;
	localparam logic [IN_W-1:0] TOP_READING  = 11'd1023;

	// result word field offsets, lowest first
	localparam int O_MISS = CNT_W;
	localparam int O_BAD  = 2 * CNT_W;
	localparam int O_TOP  = 3 * CNT_W;
	localparam int O_BOT  = O_TOP + SAMPLE_W;
	localparam int O_AVG  = O_BOT + SAMPLE_W;
	localparam int O_DEV  = O_AVG + MEAN_W;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [APB_W-1:0]      pwdata = '0;
	logic [APB_W-1:0]      prdata;
	logic                  pready;

	sensor_block_statistics_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #4 clk = ~clk;

	logic [IN_W-1:0]      sample_q[$];
	sbs_pkg::blk_result_t stats_due_q[$];
	int                   mismatches = 0;

	bit beat_done = 1'b0;
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	int src_gap_left = 0;
	int snk_gap_left = 0;
	int snk_hold_left = 0;
	int hold_token = 0;
	int hold_seen = 0;

	// predictor state
	logic [CNT_W-1:0]    blk_size_cfg = BLK_LEN_RESET;
	logic [CNT_W-1:0]    seen_cnt = '0;
	logic [CNT_W-1:0]    good_cnt = '0;
	logic [CNT_W-1:0]    lost_cnt = '0;
	logic [CNT_W-1:0]    bad_cnt = '0;
	logic [SUM_W-1:0]    sum_acc = '0;
	logic [SQ_W-1:0]     sq_acc = '0;
	logic [SAMPLE_W-1:0] top_acc = '0;
	logic [SAMPLE_W-1:0] bottom_acc = EMPTY_LOW;

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_PRINT)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, longint unsigned got, longint unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 150);
	endfunction

	function automatic logic [IN_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return IN_W'($urandom_range(0, 1023));
		if (r < 76)
			return ($urandom_range(0, 1) != 0) ? TOP_READING : '0;
		if (r < 86)
			return MARK_MISSING;
		if (r < 94)
			return MARK_CORRUPT;
		return IN_W'($urandom_range(MOST_NEG, MARK_CORRUPT - 1));
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 20; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	task automatic clear_stats();
		seen_cnt = '0;
		good_cnt = '0;
		lost_cnt = '0;
		bad_cnt = '0;
		sum_acc = '0;
		sq_acc = '0;
		top_acc = '0;
		bottom_acc = EMPTY_LOW;
	endtask

	task automatic stats_take_sample(logic [IN_W-1:0] s);
		logic [CNT_W-1:0]     lim;
		logic [SAMPLE_W-1:0]  v;
		logic [63:0]          mean;
		logic [63:0]          var_q16;
		logic [63:0]          msq;
		sbs_pkg::blk_result_t res;
		lim = blk_size_cfg;
		if (lim == '0)
			lim = CNT_W'(1);
		else if (lim > MAX_BLOCK)
			lim = MAX_BLOCK;
		if (s[IN_W-1]) begin
			if (s == MARK_MISSING)
				lost_cnt++;
			else
				bad_cnt++;
		end else begin
			v = s[SAMPLE_W-1:0];
			if (good_cnt == '0) begin
				top_acc = v;
				bottom_acc = v;
			end else begin
				if (v > top_acc)
					top_acc = v;
				if (v < bottom_acc)
					bottom_acc = v;
			end
			good_cnt++;
			sum_acc = sum_acc + SUM_W'(v);
			sq_acc = sq_acc + SQ_W'(v) * SQ_W'(v);
		end
		seen_cnt++;
		if (seen_cnt >= lim) begin
			mean = '0;
			var_q16 = '0;
			if (good_cnt != '0) begin
				mean = (64'(sum_acc) << MEAN_SHIFT) / 64'(good_cnt);
				var_q16 = (64'(sq_acc) << VAR_SHIFT) / 64'(good_cnt);
				msq = mean * mean;
				var_q16 = (var_q16 > msq) ? var_q16 - msq : 64'd0;
			end
			res.valid_total     = good_cnt;
			res.missing_total   = lost_cnt;
			res.corrupted_total = bad_cnt;
			res.peak_high       = top_acc;
			res.peak_low        = bottom_acc;
			res.average_q8      = mean[MEAN_W-1:0];
			res.deviation_q8    = DEV_W'(int_sqrt(var_q16));
			stats_due_q.push_back(res);
			clear_stats();
		end
	endtask

	// input side: predict on every accepted word
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			stats_take_sample(s_axis_tdata[IN_W-1:0]);
			beat_done = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || beat_done)) begin
			beat_done = 1'b0;
			if (src_gap_left > 0) begin
				src_gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				s_axis_tdata <= {{(IN_DATA_W-IN_W){1'b0}}, sample_q.pop_front()};
				s_axis_tvalid <= 1'b1;
				src_gap_left = src_idle_on ? pick_gap() : 0;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				snk_hold_left = HOLD_CYCLES;
			end
			if (snk_hold_left > 0) begin
				snk_hold_left--;
				m_axis_tready <= 1'b0;
			end else if (snk_gap_left > 0) begin
				snk_gap_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (snk_idle_on && $urandom_range(0, 3) == 0)
					snk_gap_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : result_check
		sbs_pkg::blk_result_t got;
		sbs_pkg::blk_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.valid_total     = m_axis_tdata[0 +: CNT_W];
			got.missing_total   = m_axis_tdata[O_MISS +: CNT_W];
			got.corrupted_total = m_axis_tdata[O_BAD +: CNT_W];
			got.peak_high       = m_axis_tdata[O_TOP +: SAMPLE_W];
			got.peak_low        = m_axis_tdata[O_BOT +: SAMPLE_W];
			got.average_q8      = m_axis_tdata[O_AVG +: MEAN_W];
			got.deviation_q8    = m_axis_tdata[O_DEV +: DEV_W];
			if (stats_due_q.size() == 0) begin
				report_mismatch($sformatf("result word with none expected: %h", m_axis_tdata));
			end else begin
				want = stats_due_q.pop_front();
				check_field("valid_total", got.valid_total, want.valid_total);
				check_field("missing_total", got.missing_total, want.missing_total);
				check_field("corrupted_total", got.corrupted_total, want.corrupted_total);
				check_field("peak_high", got.peak_high, want.peak_high);
				check_field("peak_low", got.peak_low, want.peak_low);
				check_field("average_q8", got.average_q8, want.average_q8);
				check_field("deviation_q8", got.deviation_q8, want.deviation_q8);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCH_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** sensor_block_statistics_unit: FAILED **");
		$finish;
	end

	task automatic apb_read(output logic [APB_W-1:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_BLK_LEN;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_blk_len(logic [CNT_W-1:0] sz);
		logic [APB_W-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BLK_LEN;
		pwdata <= ($urandom() & ~APB_W'(32'h7FFF)) | APB_W'(sz);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		blk_size_cfg = sz;
		apb_read(rd);
		if (rd != APB_W'(sz))
			report_mismatch($sformatf("block length read %0d expected %0d", rd, sz));
	endtask

	// sender pause: everything sent, every result back, block settled
	task automatic wait_idle();
		while (sample_q.size() != 0 || s_axis_tvalid || stats_due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [APB_W-1:0] rd;
		logic [CNT_W-1:0] sz;
		int               n;
		int               r;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apb_read(rd);
		if (rd != APB_W'(BLK_LEN_RESET))
			report_mismatch($sformatf("block length after reset %0d", rd));

		// partial block at reset size, then shrink so the next word closes it
		repeat (5) sample_q.push_back(rand_sample());
		wait_idle();
		set_blk_len(CNT_W'(3));
		sample_q.push_back(TOP_READING);
		wait_idle();

		// size zero acts as one
		set_blk_len('0);
		sample_q.push_back(TOP_READING);
		sample_q.push_back('0);
		sample_q.push_back(MARK_MISSING);
		sample_q.push_back(MARK_CORRUPT);
		sample_q.push_back(MOST_NEG);
		sample_q.push_back(11'h5A5);
		wait_idle();

		set_blk_len(CNT_W'(4));
		sample_q.push_back(TOP_READING);
		sample_q.push_back(TOP_READING);
		sample_q.push_back('0);
		sample_q.push_back('0);
		sample_q.push_back(MARK_MISSING);
		sample_q.push_back(MARK_MISSING);
		sample_q.push_back(MARK_CORRUPT);
		sample_q.push_back(MOST_NEG);
		sample_q.push_back(11'd5);
		sample_q.push_back(MARK_MISSING);
		sample_q.push_back(11'd700);
		sample_q.push_back(MARK_CORRUPT);
		wait_idle();

		// long receiver hold-off while the sender keeps going
		set_blk_len(CNT_W'(3));
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		hold_token++;
		repeat (150) sample_q.push_back(rand_sample());
		wait_idle();

		// oversize setting clamps to the largest block, full scale readings,
		// then a shorter length closes the long block
		src_idle_on = 1'b0;
		snk_idle_on = 1'b1;
		set_blk_len(15'h7FFF);
		repeat (LONG_RUN) sample_q.push_back(TOP_READING);
		wait_idle();
		set_blk_len(CNT_W'(3));
		sample_q.push_back(TOP_READING);
		wait_idle();

		src_idle_on = 1'b1;
		set_blk_len(MAX_BLOCK);
		repeat (LONG_RUN) sample_q.push_back(rand_sample());
		wait_idle();
		set_blk_len(CNT_W'(1));
		sample_q.push_back(rand_sample());
		wait_idle();

		repeat (RAND_PHASES) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				sz = CNT_W'($urandom_range(1, 4));
			else if (r < 60)
				sz = CNT_W'($urandom_range(5, 16));
			else if (r < 85)
				sz = CNT_W'($urandom_range(17, 64));
			else if (r < 90)
				sz = '0;
			else
				sz = CNT_W'($urandom_range(65, 200));
			set_blk_len(sz);
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(30, 140);
			repeat (n) sample_q.push_back(rand_sample());
			wait_idle();
		end

		repeat (TAIL) @(posedge clk);
		if (stats_due_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", stats_due_q.size()));
		if (mismatches == 0)
			$display("** sensor_block_statistics_unit: PASSED **");
		else
			$display("** sensor_block_statistics_unit: FAILED **");
		$finish;
	end

endmodule
